// ===== hdl/rlkd_pkg.sv =====
package rlkd_pkg;

  localparam int unsigned KEY_COUNT = 8;
  localparam int unsigned KEY_W     = 3;
  localparam int unsigned BOUND_W   = 16;
  localparam int unsigned WIN_REGS  = 4;
  localparam int unsigned JITTER_W  = 16;
  localparam int unsigned STABLE_W  = 3;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned IDX_LSB   = 3;

  localparam logic [JITTER_W-1:0] JITTER_RESET = 16'd100;
  localparam logic [STABLE_W-1:0] STABLE_RESET = 3'd5;

  localparam logic [DATA_W-1:0] WIN01_RESET = 64'd3377740952738206400;
  localparam logic [DATA_W-1:0] WIN23_RESET = 64'd4278476684032750080;
  localparam logic [DATA_W-1:0] WIN45_RESET = 64'd5516989602925133440;
  localparam logic [DATA_W-1:0] WIN67_RESET = 64'd6530315668370247200;

  typedef enum logic [2:0] {
    REG_JITTER = 3'd0,
    REG_STABLE = 3'd1,
    REG_WIN01  = 3'd2,
    REG_WIN23  = 3'd3,
    REG_WIN45  = 3'd4,
    REG_WIN67  = 3'd5
  } cfg_reg_e;

  typedef logic [WIN_REGS-1:0][DATA_W-1:0] windows_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } match_t;

endpackage

// ===== hdl/rlkd_match.sv =====
module rlkd_match (
  input  logic [rlkd_pkg::BOUND_W-1:0] value_i,
  input  rlkd_pkg::windows_t           windows_i,
  output rlkd_pkg::match_t             match_o
);

  logic [rlkd_pkg::BOUND_W-1:0] lo;
  logic [rlkd_pkg::BOUND_W-1:0] hi;

  // scan from the top key down so the lowest matching key wins
  always_comb begin
    match_o = '0;
    lo      = '0;
    hi      = '0;
    for (int k = rlkd_pkg::KEY_COUNT - 1; k >= 0; k--) begin
      lo = windows_i[k/2][(k%2)*32 +: rlkd_pkg::BOUND_W];
      hi = windows_i[k/2][(k%2)*32 + 16 +: rlkd_pkg::BOUND_W];
      if ((lo <= value_i) && (value_i <= hi)) begin
        match_o.hit = 1'b1;
        match_o.key = rlkd_pkg::KEY_W'(k);
      end
    end
  end

endmodule

// ===== hdl/resistor_ladder_key_decoder.sv =====
// Resistor-ladder key decoder. Takes one ADC sample beat per cycle (or a
// read-failure mark, which clears settling), waits until stable_reads samples
// in a row lie strictly closer than the jitter margin to a candidate, then
// matches the settled value against eight inclusive windows (lowest key wins)
// and emits a key index only on a transition from no-key to a key. A sample
// is registered on accept and processed once the output queue has room; the
// key it yields is registered in the output queue and then driven out;
// throughput is one sample per cycle, limited only by a two-entry output queue
// when the consumer stalls. Configuration is through an APB-style port with
// 64-bit registers at byte address 8*i; pready is always high.
module resistor_ladder_key_decoder #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   sample_i,
  input  logic                          read_failed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rlkd_pkg::KEY_W-1:0]    key_index_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlkd_pkg::ADDR_W-1:0]   paddr,
  input  logic [rlkd_pkg::DATA_W-1:0]   pwdata,
  output logic [rlkd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [rlkd_pkg::JITTER_W-1:0] jitter_q;
  logic [rlkd_pkg::STABLE_W-1:0] stable_q;
  rlkd_pkg::windows_t            windows_q;
  rlkd_pkg::cfg_reg_e            reg_sel;
  logic                          cfg_wr;

  logic                          s0_valid_q, s0_valid_d;
  logic [SAMPLE_BITS-1:0]        s0_sample_q;
  logic                          s0_failed_q;
  logic                          accept, fire;

  logic [SAMPLE_BITS-1:0]        cand_q, cand_d, cand_n, diff;
  logic [rlkd_pkg::STABLE_W-1:0] agree_q, agree_d, agree_n;
  logic                          last_known_q, last_known_d;
  logic                          agree, settle, push, pop;
  rlkd_pkg::match_t              match;

  logic [1:0]                    ocnt_q, ocnt_d;
  logic [rlkd_pkg::KEY_W-1:0]    head_q, head_d, tail_q, tail_d;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = rlkd_pkg::cfg_reg_e'(paddr[rlkd_pkg::ADDR_W-1:rlkd_pkg::IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      rlkd_pkg::REG_JITTER: prdata = rlkd_pkg::DATA_W'(jitter_q);
      rlkd_pkg::REG_STABLE: prdata = rlkd_pkg::DATA_W'(stable_q);
      rlkd_pkg::REG_WIN01:  prdata = windows_q[0];
      rlkd_pkg::REG_WIN23:  prdata = windows_q[1];
      rlkd_pkg::REG_WIN45:  prdata = windows_q[2];
      rlkd_pkg::REG_WIN67:  prdata = windows_q[3];
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_q     <= rlkd_pkg::JITTER_RESET;
      stable_q     <= rlkd_pkg::STABLE_RESET;
      windows_q[0] <= rlkd_pkg::WIN01_RESET;
      windows_q[1] <= rlkd_pkg::WIN23_RESET;
      windows_q[2] <= rlkd_pkg::WIN45_RESET;
      windows_q[3] <= rlkd_pkg::WIN67_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        rlkd_pkg::REG_JITTER: jitter_q     <= pwdata[rlkd_pkg::JITTER_W-1:0];
        rlkd_pkg::REG_STABLE: stable_q     <= pwdata[rlkd_pkg::STABLE_W-1:0];
        rlkd_pkg::REG_WIN01:  windows_q[0] <= pwdata;
        rlkd_pkg::REG_WIN23:  windows_q[1] <= pwdata;
        rlkd_pkg::REG_WIN45:  windows_q[2] <= pwdata;
        rlkd_pkg::REG_WIN67:  windows_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // input register; process a held beat whenever the output queue has room
  assign fire       = s0_valid_q && (ocnt_q != 2'd2);
  assign in_stall_o = s0_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (accept) begin
      s0_valid_d = 1'b1;
    end else if (fire) begin
      s0_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_sample_q <= sample_i[SAMPLE_BITS-1:0];
      s0_failed_q <= read_failed_i;
    end
  end

  // settling
  always_comb begin
    diff    = (s0_sample_q >= cand_q) ? (s0_sample_q - cand_q) : (cand_q - s0_sample_q);
    agree   = rlkd_pkg::JITTER_W'(diff) < jitter_q;
    agree_n = agree ? (agree_q + rlkd_pkg::STABLE_W'(1)) : '0;
    cand_n  = agree ? cand_q : s0_sample_q;
    settle  = fire && !s0_failed_q && (agree_n >= stable_q);
  end

  rlkd_match u_match (
    .value_i   (rlkd_pkg::BOUND_W'(cand_n)),
    .windows_i (windows_q),
    .match_o   (match)
  );

  always_comb begin
    cand_d       = cand_q;
    agree_d      = agree_q;
    last_known_d = last_known_q;
    if (fire) begin
      if (s0_failed_q || settle) begin
        cand_d  = '0;
        agree_d = '0;
      end else begin
        cand_d  = cand_n;
        agree_d = agree_n;
      end
      if (settle) begin
        last_known_d = match.hit;
      end
    end
  end

  assign push = settle && match.hit && !last_known_q;
  assign pop  = out_valid_o && !out_stall_i;

  // two-entry output queue
  always_comb begin
    ocnt_d = ocnt_q;
    head_d = head_q;
    tail_d = tail_q;
    case (ocnt_q)
      2'd0: begin
        if (push) begin
          head_d = match.key;
          ocnt_d = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_d = match.key;
        end else if (push) begin
          tail_d = match.key;
          ocnt_d = 2'd2;
        end else if (pop) begin
          ocnt_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_d = tail_q;
          ocnt_d = 2'd1;
        end
      end
    endcase
  end

  assign out_valid_o = (ocnt_q != 2'd0);
  assign key_index_o = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      cand_q       <= '0;
      agree_q      <= '0;
      last_known_q <= 1'b0;
      ocnt_q       <= 2'd0;
    end else begin
      s0_valid_q   <= s0_valid_d;
      cand_q       <= cand_d;
      agree_q      <= agree_d;
      last_known_q <= last_known_d;
      ocnt_q       <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

`ifndef SYNTHESIS
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3)
    else $error("output queue count out of range");

  a_settle_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settle |=> (cand_q == '0) && (agree_q == '0))
    else $error("settled reading did not clear candidate and count");

  a_push_sets_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> last_known_q && out_valid_o)
    else $error("emitted key did not mark key known");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ocnt_q == 2'd2) && s0_valid_q)
    else $error("input stalled without a full output queue");
`endif

endmodule
